/* rtl/tpm_pkg.sv */
// Shared widths, register indexes and controller command type for trajectory path metrics.
`timescale 1ns / 1ps

package tpm_pkg;

    // Field widths
    localparam int COORD_W = 32;                 // pose and target coordinates
    localparam int TOTAL_W = 48;                 // path length total
    localparam int DIST_W  = COORD_W + 2;        // distance / square root result
    localparam int SPEED_W = 40;                 // peak speed result
    localparam int FRAC_W  = 16;                 // fractional bits of Q16.16
    localparam int STIME_W = 32;                 // step time register
    localparam int CFG_IDX_W = 2;                // config register index

    // Square root: radicand padded to whole bit pairs, two pairs per cycle
    localparam int RAD_W      = 2 * DIST_W;
    localparam int ROOT_STEPS = DIST_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS + 1);

    // Division: (longest << FRAC_W) / step_time, two quotient bits per cycle
    localparam int QUO_W     = DIST_W + FRAC_W;
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Stream payload widths
    localparam int S_DATA_W = 2 * COORD_W;
    localparam int M_FIELDS_W = TOTAL_W + SPEED_W + DIST_W;
    localparam int M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 2'd2;

    localparam logic [STIME_W-1:0] STEP_TIME_RESET = 32'h0001_0000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture pose, form step deltas
        logic sq_first;    // square first magnitude
        logic sq_second;   // add second square, start square root
        logic root_step;   // two square root iterations
        logic commit;      // update totals, form target deltas
        logic div_start;   // load divider
        logic div_step;    // two divider iterations
        logic out_load;    // load result register, clear on last pose
    } tpm_cmd_t;

endpackage

/* rtl/tpm_ctrl.sv */
// Controller state machine sequencing the step root, target root and divider.
`timescale 1ns / 1ps

module tpm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output tpm_pkg::tpm_cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_SQ_A   = 11'b000_0000_0010,
        S_SQ_B   = 11'b000_0000_0100,
        S_ROOT   = 11'b000_0000_1000,
        S_COMMIT = 11'b000_0001_0000,
        S_TSQ_A  = 11'b000_0010_0000,
        S_TSQ_B  = 11'b000_0100_0000,
        S_TROOT  = 11'b000_1000_0000,
        S_WAIT   = 11'b001_0000_0000,
        S_OUT    = 11'b010_0000_0000,
        S_SPARE  = 11'b100_0000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [tpm_pkg::ROOT_CNT_W-1:0]  root_cnt_reg, root_cnt_next;
    logic [tpm_pkg::DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        root_cnt_next = root_cnt_reg;
        div_cnt_next  = div_cnt_reg;
        cmd           = '0;

        // divider runs on its own count, overlapping the target root
        if (div_cnt_reg != '0) begin
            cmd.div_step = 1'b1;
            div_cnt_next = div_cnt_reg - 1'b1;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SQ_A;
                end
            end
            S_SQ_A: begin
                cmd.sq_first = 1'b1;
                state_next   = S_SQ_B;
            end
            S_SQ_B: begin
                cmd.sq_second = 1'b1;
                root_cnt_next = tpm_pkg::ROOT_CNT_W'(tpm_pkg::ROOT_STEPS - 1);
                state_next    = S_ROOT;
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                root_cnt_next = root_cnt_reg - 1'b1;
                if (root_cnt_reg == '0) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_TSQ_A;
            end
            S_TSQ_A: begin
                cmd.sq_first  = 1'b1;
                cmd.div_start = 1'b1;
                div_cnt_next  = tpm_pkg::DIV_CNT_W'(tpm_pkg::DIV_STEPS);
                state_next    = S_TSQ_B;
            end
            S_TSQ_B: begin
                cmd.sq_second = 1'b1;
                root_cnt_next = tpm_pkg::ROOT_CNT_W'(tpm_pkg::ROOT_STEPS - 1);
                state_next    = S_TROOT;
            end
            S_TROOT: begin
                cmd.root_step = 1'b1;
                root_cnt_next = root_cnt_reg - 1'b1;
                if (root_cnt_reg == '0) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (div_cnt_reg == '0) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = cmd.out_load || (out_valid_reg && !m_tready);
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            root_cnt_reg  <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            root_cnt_reg  <= root_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/tpm_datapath.sv */
// Datapath: config registers, trajectory state, squarer, square root and divider units.
`timescale 1ns / 1ps

module tpm_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tpm_pkg::tpm_cmd_t                   cmd,
    input  logic [tpm_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                s_tlast,
    input  logic                                cfg_wr,
    input  logic [tpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tpm_pkg::STIME_W-1:0]         cfg_data,
    output logic [tpm_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tlast
);

    localparam int CW    = tpm_pkg::COORD_W;
    localparam int DW    = tpm_pkg::DIST_W;
    localparam int TW    = tpm_pkg::TOTAL_W;
    localparam int SW    = tpm_pkg::SPEED_W;
    localparam int QW    = tpm_pkg::QUO_W;
    localparam int STW   = tpm_pkg::STIME_W;
    localparam int RW    = tpm_pkg::RAD_W;
    localparam int REM_W = DW + 2;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DW-1:0]    root;
    } root_st_t;

    typedef struct packed {
        logic [STW-1:0] rem;
        logic [QW-1:0]  dq;
    } div_st_t;

    // One restoring square root iteration on the next bit pair
    function automatic root_st_t root_iter(input root_st_t st, input logic [1:0] pair);
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        root_st_t         r;
        rem_sh = {st.rem, pair};
        trial  = {{(REM_W - DW){1'b0}}, st.root, 2'b01};
        if (rem_sh >= trial) begin
            r.rem  = REM_W'(rem_sh - trial);
            r.root = {st.root[DW-2:0], 1'b1};
        end else begin
            r.rem  = REM_W'(rem_sh);
            r.root = {st.root[DW-2:0], 1'b0};
        end
        return r;
    endfunction

    // One restoring division iteration; quotient bits shift in behind the dividend
    function automatic div_st_t div_iter(input div_st_t st, input logic [STW-1:0] den);
        logic [STW:0] rem_sh;
        div_st_t      r;
        rem_sh = {st.rem, st.dq[QW-1]};
        if (rem_sh >= {1'b0, den}) begin
            r.rem = STW'(rem_sh - {1'b0, den});
            r.dq  = {st.dq[QW-2:0], 1'b1};
        end else begin
            r.rem = STW'(rem_sh);
            r.dq  = {st.dq[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    // Absolute difference of two signed coordinates
    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic signed [CW:0] d;
        logic        [CW:0] m;
        d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
        m = d[CW] ? (~d + 1'b1) : d;
        return m[CW-1:0];
    endfunction

    // Config registers
    logic [CW-1:0]  target_x_reg, target_y_reg;
    logic [STW-1:0] step_time_reg;

    // Trajectory state
    logic [CW-1:0] prev_x_reg, prev_y_reg;
    logic          have_prev_reg;
    logic [TW-1:0] total_reg;
    logic [DW-1:0] longest_reg;

    // Working registers
    logic [CW-1:0]   pose_x_reg, pose_y_reg;
    logic            last_reg;
    logic [CW-1:0]   mag_a_reg, mag_b_reg;
    logic [2*CW-1:0] acc_reg;
    logic [RW-1:0]   rad_reg;
    root_st_t        root_reg;
    div_st_t         div_reg;

    // Result register
    logic [TW-1:0] out_path_reg;
    logic [SW-1:0] out_speed_reg;
    logic [DW-1:0] out_err_reg;
    logic          out_last_reg;

    logic [CW-1:0]   in_x, in_y;
    logic [2*CW-1:0] sq_prod;
    logic [CW-1:0]   sq_op;
    root_st_t        root_mid, root_new;
    div_st_t         div_mid, div_new;
    logic [TW:0]     total_sum;
    logic [TW-1:0]   total_new;
    logic [SW-1:0]   speed;

    assign in_x = s_tdata[CW-1:0];
    assign in_y = s_tdata[2*CW-1:CW];

    // Shared squarer
    assign sq_op   = cmd.sq_first ? mag_a_reg : mag_b_reg;
    assign sq_prod = sq_op * sq_op;

    // Two root iterations per cycle, pairs taken from the top of the radicand
    assign root_mid = root_iter(root_reg, rad_reg[RW-1:RW-2]);
    assign root_new = root_iter(root_mid, rad_reg[RW-3:RW-4]);

    // Two divider iterations per cycle
    assign div_mid = div_iter(div_reg, step_time_reg);
    assign div_new = div_iter(div_mid, step_time_reg);

    // Saturating path length update with the finished step length
    assign total_sum = {1'b0, total_reg} + {{(TW + 1 - DW){1'b0}}, root_reg.root};
    assign total_new = total_sum[TW] ? {TW{1'b1}} : total_sum[TW-1:0];

    // Peak speed with saturation and zero step time handling
    always_comb begin
        if (step_time_reg == '0) begin
            speed = (longest_reg != '0) ? {SW{1'b1}} : '0;
        end else if (div_reg.dq[QW-1:SW] != '0) begin
            speed = {SW{1'b1}};
        end else begin
            speed = div_reg.dq[SW-1:0];
        end
    end

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            step_time_reg <= tpm_pkg::STEP_TIME_RESET;
        end else if (cfg_wr) begin
            case (cfg_index)
                tpm_pkg::REG_TARGET_X:  target_x_reg  <= cfg_data[CW-1:0];
                tpm_pkg::REG_TARGET_Y:  target_y_reg  <= cfg_data[CW-1:0];
                tpm_pkg::REG_STEP_TIME: step_time_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Trajectory state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            total_reg     <= '0;
            longest_reg   <= '0;
        end else if (cmd.commit) begin
            prev_x_reg    <= pose_x_reg;
            prev_y_reg    <= pose_y_reg;
            have_prev_reg <= 1'b1;
            if (have_prev_reg) begin
                total_reg <= total_new;
                if (root_reg.root > longest_reg) begin
                    longest_reg <= root_reg.root;
                end
            end
        end else if (cmd.out_load && last_reg) begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            total_reg     <= '0;
            longest_reg   <= '0;
        end
    end

    // Pose capture and delta magnitudes
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pose_x_reg <= in_x;
            pose_y_reg <= in_y;
            last_reg   <= s_tlast;
            mag_a_reg  <= abs_diff(in_x, prev_x_reg);
            mag_b_reg  <= abs_diff(in_y, prev_y_reg);
        end else if (cmd.commit) begin
            mag_a_reg  <= abs_diff(target_x_reg, pose_x_reg);
            mag_b_reg  <= abs_diff(target_y_reg, pose_y_reg);
        end
    end

    // Sum of squares and square root unit
    always_ff @(posedge aclk) begin
        if (cmd.sq_first) begin
            acc_reg <= sq_prod;
        end
        if (cmd.sq_second) begin
            rad_reg  <= RW'({1'b0, acc_reg} + {1'b0, sq_prod});
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg  <= {rad_reg[RW-5:0], 4'b0000};
            root_reg <= root_new;
        end
    end

    // Divider unit
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_reg.rem <= '0;
            div_reg.dq  <= {longest_reg, {tpm_pkg::FRAC_W{1'b0}}};
        end else if (cmd.div_step) begin
            div_reg <= div_new;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_path_reg  <= total_reg;
            out_speed_reg <= speed;
            out_err_reg   <= root_reg.root;
            out_last_reg  <= last_reg;
        end
    end

    assign m_tdata = {{(tpm_pkg::M_DATA_W - tpm_pkg::M_FIELDS_W){1'b0}},
                      out_err_reg, out_speed_reg, out_path_reg};
    assign m_tlast = out_last_reg;

endmodule

/* rtl/trajectory_path_metrics_top.sv */
// One pose is in work at a time: the next pose is taken only after the result of the
// last one is loaded into the output register; the two square roots (two bit pairs a
// cycle), the divider tail and the output load set the pace while results are taken.
// A finished result waits in the output register while the next pose is taken.
// Reset (aresetn low, synchronous) clears the trajectory state, targets to zero
// and step time to 1.0 s; config writes are taken in every cycle.
`timescale 1ns / 1ps

module trajectory_path_metrics_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // pose in: tdata = pose_x [31:0], pose_y [63:32]; tlast = last_pose
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tpm_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                               s_tlast,
    // result out: tdata = path_length [47:0], peak_speed [87:48],
    // target_error [121:88], zero [127:122]; tlast = trajectory_done
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tpm_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast,
    // config write: index 0 target_x, 1 target_y, 2 step_time
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpm_pkg::STIME_W-1:0]        cfg_data
);

    tpm_pkg::tpm_cmd_t cmd;

    assign cfg_ready = 1'b1;

    tpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tpm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* rtl/tpm_chk.sv */
// Port-level checker for trajectory path metrics, bound to the top level.
`timescale 1ns / 1ps

module tpm_chk (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tpm_pkg::M_DATA_W-1:0]       m_tdata,
    input logic                               m_tlast,
    input logic                               cfg_valid,
    input logic                               cfg_ready
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // One pose at a time: input closes after each accepted transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second pose taken while one is in work");

    // No result appears in the cycle after a pose is taken with no result pending
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared right after pose");

    // Reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not empty after reset");

    // Config writes are never stalled
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind trajectory_path_metrics_top tpm_chk u_tpm_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
